@@ rtl/fde_pkg.sv @@
// ---------------------------------------------------------------------------
// fde_pkg
// Shared types, codes and constants of the framebuffer draw engine.
// ---------------------------------------------------------------------------
package fde_pkg;

    localparam int DEF_MAX_WIDTH  = 128;
    localparam int DEF_MAX_HEIGHT = 128;

    localparam int COORD_W = 12;
    localparam int PIX_W   = 8;
    localparam int COLOR_W = 32;
    localparam int KIND_W  = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int ERR_W   = 15;

    localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PUT   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_GET   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_FILL  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_LINE  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT  = 2'd2;

    localparam logic [PIX_W-1:0] RESET_DIM = 8'd128;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_LINE,
        ST_GET,
        ST_READ,
        ST_DONE
    } state_t;

    // One pixel access from the walker to the store
    typedef struct packed {
        logic               wr;
        logic               rd;
        logic [PIX_W-1:0]   x;
        logic [PIX_W-1:0]   y;
        logic [COLOR_W-1:0] color;
    } px_t;

endpackage

@@ rtl/fde_if.sv @@
// ---------------------------------------------------------------------------
// fde_cmd_if / fde_res_if
// Valid/ready channels for draw commands and read results.
// ---------------------------------------------------------------------------
interface fde_cmd_if
    import fde_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic [COORD_W-1:0] far_x;
    logic [COORD_W-1:0] far_y;
    logic [COLOR_W-1:0] color;

    modport source (output valid, kind, pos_x, pos_y, far_x, far_y, color, input ready);
    modport sink   (input valid, kind, pos_x, pos_y, far_x, far_y, color, output ready);
endinterface

interface fde_res_if
    import fde_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] read_color;

    modport source (output valid, read_color, input ready);
    modport sink   (input valid, read_color, output ready);
endinterface

@@ rtl/fde_store.sv @@
// ---------------------------------------------------------------------------
// fde_store
// Pixel memory: registers the linear address, then writes or reads one word.
// ---------------------------------------------------------------------------
module fde_store
    import fde_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  px_t                px,
    input  logic [PIX_W-1:0]   eff_w,
    output logic               rvalid,
    output logic [COLOR_W-1:0] rdata
);

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SUM_W  = 2 * PIX_W;

    logic [COLOR_W-1:0] mem [DEPTH];

    logic [SUM_W-1:0]   lin_addr;
    logic [ADDR_W-1:0]  addr_reg;
    logic               wr_reg;
    logic               rd_reg;
    logic [COLOR_W-1:0] data_reg;
    logic [COLOR_W-1:0] rdata_reg;
    logic               rvalid_reg;

    // in-bounds pixels only, so y * w + x stays below the store depth
    assign lin_addr = SUM_W'(px.y) * SUM_W'(eff_w) + SUM_W'(px.x);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg     <= 1'b0;
            rd_reg     <= 1'b0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            wr_reg     <= px.wr;
            rd_reg     <= px.rd;
            rvalid_reg <= rd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= ADDR_W'(lin_addr);
        data_reg <= px.color;
    end

    always_ff @(posedge clk)
    begin
        if (wr_reg)
        begin
            mem[addr_reg] <= data_reg;
        end
        if (rd_reg)
        begin
            rdata_reg <= mem[addr_reg];
        end
    end

    assign rvalid = rvalid_reg;
    assign rdata  = rdata_reg;

endmodule

@@ rtl/fde_walker.sv @@
// ---------------------------------------------------------------------------
// fde_walker
// Command sequencer: walks fill rectangles and Bresenham lines one pixel per
// cycle, clips each pixel and issues pixel accesses to the store.
// ---------------------------------------------------------------------------
module fde_walker
    import fde_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               enabled,
    input  logic [PIX_W-1:0]   eff_w,
    input  logic [PIX_W-1:0]   eff_h,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  logic [KIND_W-1:0]  kind,
    input  logic [COORD_W-1:0] pos_x,
    input  logic [COORD_W-1:0] pos_y,
    input  logic [COORD_W-1:0] far_x,
    input  logic [COORD_W-1:0] far_y,
    input  logic [COLOR_W-1:0] color,
    input  logic               rvalid,
    output px_t                px,
    output logic               done_valid,
    output logic               done_get,
    input  logic               done_ready
);

    state_t state_reg, state_next;

    logic [COORD_W-1:0] lx_reg, lx_next, ly_reg, ly_next;
    logic [COORD_W-1:0] ex_reg, ex_next, ey_reg, ey_next;
    logic [COORD_W-1:0] dx_reg, dx_next, dy_reg, dy_next;
    logic               sx_reg, sx_next, sy_reg, sy_next;
    logic signed [ERR_W-1:0] err_reg, err_next;
    logic [PIX_W-1:0]   cx_reg, cx_next, cy_reg, cy_next;
    logic [PIX_W-1:0]   xs_reg, xs_next, xe_reg, xe_next, ye_reg, ye_next;
    logic [COLOR_W-1:0] color_reg, color_next;
    logic               get_reg, get_next;

    logic [COORD_W:0]   w_ext, h_ext, sum_x, sum_y;
    logic [PIX_W-1:0]   fxe, fye;
    logic               cmd_xfer;
    logic               pos_in, line_in;
    logic [COORD_W-1:0] adx, ady;
    logic signed [ERR_W:0]   e2;
    logic signed [ERR_W:0]   ndy;
    logic               step_x, step_y;
    logic [PIX_W:0]     cx_inc, cy_inc;

    assign cmd_xfer = cmd_valid && cmd_ready;
    assign w_ext    = (COORD_W+1)'(eff_w);
    assign h_ext    = (COORD_W+1)'(eff_h);
    assign sum_x    = {1'b0, pos_x} + {1'b0, far_x};
    assign sum_y    = {1'b0, pos_y} + {1'b0, far_y};
    assign fxe      = (sum_x > w_ext) ? eff_w : sum_x[PIX_W-1:0];
    assign fye      = (sum_y > h_ext) ? eff_h : sum_y[PIX_W-1:0];
    assign pos_in   = ({1'b0, pos_x} < w_ext) && ({1'b0, pos_y} < h_ext);
    assign line_in  = ({1'b0, lx_reg} < w_ext) && ({1'b0, ly_reg} < h_ext);
    assign adx      = (far_x > pos_x) ? far_x - pos_x : pos_x - far_x;
    assign ady      = (far_y > pos_y) ? far_y - pos_y : pos_y - far_y;

    assign e2     = {err_reg, 1'b0};
    assign ndy    = -$signed((ERR_W+1)'(dy_reg));
    assign step_x = e2 > ndy;
    assign step_y = e2 < $signed((ERR_W+1)'(dx_reg));
    assign cx_inc = {1'b0, cx_reg} + 1'b1;
    assign cy_inc = {1'b0, cy_reg} + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lx_reg    <= lx_next;
        ly_reg    <= ly_next;
        ex_reg    <= ex_next;
        ey_reg    <= ey_next;
        dx_reg    <= dx_next;
        dy_reg    <= dy_next;
        sx_reg    <= sx_next;
        sy_reg    <= sy_next;
        err_reg   <= err_next;
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        xs_reg    <= xs_next;
        xe_reg    <= xe_next;
        ye_reg    <= ye_next;
        color_reg <= color_next;
        get_reg   <= get_next;
    end

    // next state and walk registers
    always_comb
    begin
        state_next = state_reg;
        lx_next    = lx_reg;
        ly_next    = ly_reg;
        ex_next    = ex_reg;
        ey_next    = ey_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        sx_next    = sx_reg;
        sy_next    = sy_reg;
        err_next   = err_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        xs_next    = xs_reg;
        xe_next    = xe_reg;
        ye_next    = ye_reg;
        color_next = color_reg;
        get_next   = get_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_xfer)
                begin
                    color_next = color;
                    get_next   = 1'b0;
                    lx_next    = pos_x;
                    ly_next    = pos_y;
                    state_next = ST_DONE;
                    if (enabled)
                    begin
                        case (kind)
                            KIND_CLEAR:
                            begin
                                cx_next = '0;
                                cy_next = '0;
                                xs_next = '0;
                                xe_next = eff_w;
                                ye_next = eff_h;
                                if (eff_w != '0 && eff_h != '0)
                                begin
                                    state_next = ST_FILL;
                                end
                            end
                            KIND_FILL:
                            begin
                                cx_next = pos_x[PIX_W-1:0];
                                cy_next = pos_y[PIX_W-1:0];
                                xs_next = pos_x[PIX_W-1:0];
                                xe_next = fxe;
                                ye_next = fye;
                                if (pos_x < COORD_W'(fxe) && pos_y < COORD_W'(fye))
                                begin
                                    state_next = ST_FILL;
                                end
                            end
                            KIND_PUT:
                            begin
                                // a line whose ends coincide: one clipped pixel
                                ex_next    = pos_x;
                                ey_next    = pos_y;
                                dx_next    = '0;
                                dy_next    = '0;
                                err_next   = '0;
                                state_next = ST_LINE;
                            end
                            KIND_LINE:
                            begin
                                ex_next    = far_x;
                                ey_next    = far_y;
                                dx_next    = adx;
                                dy_next    = ady;
                                sx_next    = pos_x < far_x;
                                sy_next    = pos_y < far_y;
                                err_next   = $signed(ERR_W'(adx)) - $signed(ERR_W'(ady));
                                state_next = ST_LINE;
                            end
                            KIND_GET:
                            begin
                                if (pos_in)
                                begin
                                    get_next   = 1'b1;
                                    state_next = ST_GET;
                                end
                            end
                            default:
                            begin
                                state_next = ST_DONE;
                            end
                        endcase
                    end
                end
            end
            ST_FILL:
            begin
                if (cx_inc == (PIX_W+1)'(xe_reg))
                begin
                    cx_next = xs_reg;
                    cy_next = cy_inc[PIX_W-1:0];
                    if (cy_inc == (PIX_W+1)'(ye_reg))
                    begin
                        state_next = ST_DONE;
                    end
                end
                else
                begin
                    cx_next = cx_inc[PIX_W-1:0];
                end
            end
            ST_LINE:
            begin
                if (lx_reg == ex_reg && ly_reg == ey_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    err_next = err_reg
                             - (step_x ? $signed(ERR_W'(dy_reg)) : '0)
                             + (step_y ? $signed(ERR_W'(dx_reg)) : '0);
                    if (step_x)
                    begin
                        lx_next = sx_reg ? lx_reg + 1'b1 : lx_reg - 1'b1;
                    end
                    if (step_y)
                    begin
                        ly_next = sy_reg ? ly_reg + 1'b1 : ly_reg - 1'b1;
                    end
                end
            end
            ST_GET:
            begin
                state_next = ST_READ;
            end
            ST_READ:
            begin
                if (rvalid)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (done_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        px.wr      = 1'b0;
        px.rd      = 1'b0;
        px.x       = lx_reg[PIX_W-1:0];
        px.y       = ly_reg[PIX_W-1:0];
        px.color   = color_reg;
        cmd_ready  = 1'b0;
        done_valid = 1'b0;
        done_get   = get_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                cmd_ready = 1'b1;
            end
            ST_FILL:
            begin
                px.wr = 1'b1;
                px.x  = cx_reg;
                px.y  = cy_reg;
            end
            ST_LINE:
            begin
                px.wr = line_in;
            end
            ST_GET:
            begin
                px.rd = 1'b1;
            end
            ST_READ:
            begin
                px.rd = 1'b0;
            end
            ST_DONE:
            begin
                done_valid = 1'b1;
            end
            default:
            begin
                cmd_ready = 1'b0;
            end
        endcase
    end

endmodule

@@ rtl/framebuffer_draw_engine_core.sv @@
// ---------------------------------------------------------------------------
// framebuffer_draw_engine_core
// 2D draw engine over a 32-bit pixel store: clear, put, get, fill, line.
// ---------------------------------------------------------------------------
// One command is in flight at a time; the next is taken once the previous one
// has handed its result to the output register, even while that result still
// waits to be taken. Clear and fill walk the clipped rectangle one pixel per
// cycle, a line walks max(|dx|, |dy|) + 1 pixels and clips each of them, and
// get goes through the address register and the registered memory read of the
// store. The single-port pixel memory takes one access per cycle. The pixel
// memory holds no reset value: read only pixels that a clear or a write has
// set. Configuration writes are taken any cycle but must only be made while no
// command is in flight.
module framebuffer_draw_engine_core
    import fde_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    fde_cmd_if.sink               cmd,
    fde_res_if.source             res,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic               enabled_reg;
    logic [PIX_W-1:0]   width_reg;
    logic [PIX_W-1:0]   height_reg;
    logic [PIX_W-1:0]   eff_w, eff_h;

    px_t                px;
    logic               rvalid;
    logic [COLOR_W-1:0] rdata;
    logic               done_valid, done_get, done_ready;

    logic               out_valid_reg;
    logic [COLOR_W-1:0] out_color_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg <= 1'b0;
            width_reg   <= RESET_DIM;
            height_reg  <= RESET_DIM;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ENABLED: enabled_reg <= cfg_data[0];
                CFG_WIDTH:   width_reg   <= cfg_data;
                CFG_HEIGHT:  height_reg  <= cfg_data;
                default:     enabled_reg <= enabled_reg;
            endcase
        end
    end

    // clamp the active area to the store geometry
    assign eff_w = ((COORD_W+2)'(width_reg) > (COORD_W+2)'(MAX_WIDTH))
                 ? PIX_W'(MAX_WIDTH) : width_reg;
    assign eff_h = ((COORD_W+2)'(height_reg) > (COORD_W+2)'(MAX_HEIGHT))
                 ? PIX_W'(MAX_HEIGHT) : height_reg;

    fde_walker u_walker (
        .clk        (clk),
        .rst_n      (rst_n),
        .enabled    (enabled_reg),
        .eff_w      (eff_w),
        .eff_h      (eff_h),
        .cmd_valid  (cmd.valid),
        .cmd_ready  (cmd.ready),
        .kind       (cmd.kind),
        .pos_x      (cmd.pos_x),
        .pos_y      (cmd.pos_y),
        .far_x      (cmd.far_x),
        .far_y      (cmd.far_y),
        .color      (cmd.color),
        .rvalid     (rvalid),
        .px         (px),
        .done_valid (done_valid),
        .done_get   (done_get),
        .done_ready (done_ready)
    );

    fde_store #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_store (
        .clk    (clk),
        .rst_n  (rst_n),
        .px     (px),
        .eff_w  (eff_w),
        .rvalid (rvalid),
        .rdata  (rdata)
    );

    // output register: load when empty or being drained
    assign done_ready = !out_valid_reg || res.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (done_ready)
        begin
            out_valid_reg <= done_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done_ready && done_valid)
        begin
            out_color_reg <= done_get ? rdata : '0;
        end
    end

    assign res.valid      = out_valid_reg;
    assign res.read_color = out_color_reg;

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the framebuffer draw engine: a behavioral copy of
// the pixel store predicts read_color for each command transfer, and results
// are matched in order under random idling, back-pressure and register sweeps.
// ---------------------------------------------------------------------------
module tb_top
    import fde_pkg::*;
();

    localparam int CANVAS_DEPTH = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;
    localparam int STALL_LIMIT  = 80000;
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = 20;
    localparam int PHASE_COUNT  = 10;
    localparam int PHASE_ITEMS  = 50;

    localparam logic [KIND_W-1:0]    KIND_RSVD_5 = 3'd5;
    localparam logic [KIND_W-1:0]    KIND_RSVD_6 = 3'd6;
    localparam logic [KIND_W-1:0]    KIND_RSVD_7 = 3'd7;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE   = 2'd3;

    typedef struct {
        logic [KIND_W-1:0]  kind;
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic [COORD_W-1:0] far_x;
        logic [COORD_W-1:0] far_y;
        logic [COLOR_W-1:0] color;
    } draw_cmd_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    fde_cmd_if cmd_bus ();
    fde_res_if res_bus ();

    framebuffer_draw_engine_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_bus),
        .res       (res_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mirror of the engine: pixel store and registers
    logic [COLOR_W-1:0]    canvas [CANVAS_DEPTH];
    logic                  reg_enable;
    logic [CFG_DATA_W-1:0] reg_width;
    logic [CFG_DATA_W-1:0] reg_height;

    logic [COLOR_W-1:0] read_color_q [$];
    int                 kind_seen [8];
    int                 commands_sent;
    int                 results_checked;
    int                 mismatches;
    int                 idle_cycles;
    int                 hold_request;
    bit                 quiet;

    function automatic int vis_width();
        return (reg_width > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : int'(reg_width);
    endfunction

    function automatic int vis_height();
        return (reg_height > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : int'(reg_height);
    endfunction

    function automatic void plot_pixel(int x, int y, logic [COLOR_W-1:0] c);
        int w;
        int h;
        int addr;
        w = vis_width();
        h = vis_height();
        if (x < 0 || y < 0 || x >= w || y >= h)
            return;
        addr = y * w + x;
        if (addr < CANVAS_DEPTH)
            canvas[addr] = c;
    endfunction

    function automatic logic [COLOR_W-1:0] sample_pixel(int x, int y);
        int w;
        int h;
        int addr;
        w = vis_width();
        h = vis_height();
        if (x >= w || y >= h)
            return '0;
        addr = y * w + x;
        return (addr < CANVAS_DEPTH) ? canvas[addr] : '0;
    endfunction

    function automatic void paint_rect(int x, int y, int rw, int rh, logic [COLOR_W-1:0] c);
        int xe;
        int ye;
        xe = x + rw;
        ye = y + rh;
        if (xe > vis_width())
            xe = vis_width();
        if (ye > vis_height())
            ye = vis_height();
        for (int cy = y; cy < ye; cy++)
            for (int cx = x; cx < xe; cx++)
                plot_pixel(cx, cy, c);
    endfunction

    // Bresenham walk; runs past the clip edges until the far end is reached
    function automatic void trace_line(int x0, int y0, int x1, int y1, logic [COLOR_W-1:0] c);
        int dx;
        int dy;
        int sx;
        int sy;
        int err;
        int e2;
        bit done;
        dx = (x1 > x0) ? x1 - x0 : x0 - x1;
        dy = (y1 > y0) ? y1 - y0 : y0 - y1;
        sx = (x0 < x1) ? 1 : -1;
        sy = (y0 < y1) ? 1 : -1;
        err = dx - dy;
        done = 1'b0;
        while (!done)
        begin
            plot_pixel(x0, y0, c);
            if (x0 == x1 && y0 == y1)
                done = 1'b1;
            else
            begin
                e2 = 2 * err;
                if (e2 > -dy)
                begin
                    err -= dy;
                    x0 += sx;
                end
                if (e2 < dx)
                begin
                    err += dx;
                    y0 += sy;
                end
            end
        end
    endfunction

    function automatic logic [COLOR_W-1:0] apply_command(draw_cmd_t c);
        logic [COLOR_W-1:0] result;
        result = '0;
        if (reg_enable)
        begin
            case (c.kind)
                KIND_CLEAR: paint_rect(0, 0, vis_width(), vis_height(), c.color);
                KIND_PUT:   plot_pixel(int'(c.pos_x), int'(c.pos_y), c.color);
                KIND_GET:   result = sample_pixel(int'(c.pos_x), int'(c.pos_y));
                KIND_FILL:  paint_rect(int'(c.pos_x), int'(c.pos_y),
                                       int'(c.far_x), int'(c.far_y), c.color);
                KIND_LINE:  trace_line(int'(c.pos_x), int'(c.pos_y),
                                       int'(c.far_x), int'(c.far_y), c.color);
                default:    ;
            endcase
        end
        return result;
    endfunction

    // Mostly inside the visible area, some just past its edge, a few anywhere
    function automatic logic [COORD_W-1:0] pick_coord(int span);
        int roll;
        logic [COORD_W-1:0] v;
        roll = $urandom_range(0, 19);
        if (roll == 0)
            v = COORD_W'($urandom);
        else if (roll < 3)
            v = COORD_W'(span + $urandom_range(0, 3));
        else if (span > 0)
            v = COORD_W'($urandom_range(0, span - 1));
        else
            v = COORD_W'($urandom_range(0, 3));
        return v;
    endfunction

    task automatic send_cmd(input logic [KIND_W-1:0] kind, input logic [COORD_W-1:0] px,
                            input logic [COORD_W-1:0] py, input logic [COORD_W-1:0] fx,
                            input logic [COORD_W-1:0] fy, input logic [COLOR_W-1:0] color);
        draw_cmd_t c;
        c.kind  = kind;
        c.pos_x = px;
        c.pos_y = py;
        c.far_x = fx;
        c.far_y = fy;
        c.color = color;
        cmd_bus.valid <= 1'b1;
        cmd_bus.kind  <= kind;
        cmd_bus.pos_x <= px;
        cmd_bus.pos_y <= py;
        cmd_bus.far_x <= fx;
        cmd_bus.far_y <= fy;
        cmd_bus.color <= color;
        @(posedge clk);
        while (cmd_bus.ready !== 1'b1)
            @(posedge clk);
        read_color_q.push_back(apply_command(c));
        kind_seen[kind]++;
        commands_sent++;
    endtask

    task automatic send_random();
        int roll;
        logic [KIND_W-1:0]  k;
        logic [COORD_W-1:0] fx;
        logic [COORD_W-1:0] fy;
        roll = $urandom_range(0, 99);
        if (roll < 4)
            k = KIND_CLEAR;
        else if (roll < 28)
            k = KIND_PUT;
        else if (roll < 56)
            k = KIND_GET;
        else if (roll < 76)
            k = KIND_FILL;
        else if (roll < 95)
            k = KIND_LINE;
        else
        begin
            case ($urandom_range(0, 2))
                0:       k = KIND_RSVD_5;
                1:       k = KIND_RSVD_6;
                default: k = KIND_RSVD_7;
            endcase
        end
        if (k == KIND_FILL && $urandom_range(0, 9) != 0)
        begin
            fx = COORD_W'($urandom_range(0, 10));
            fy = COORD_W'($urandom_range(0, 10));
        end
        else if (k == KIND_LINE)
        begin
            fx = pick_coord(vis_width());
            fy = pick_coord(vis_height());
        end
        else
        begin
            fx = COORD_W'($urandom);
            fy = COORD_W'($urandom);
        end
        send_cmd(k, pick_coord(vis_width()), pick_coord(vis_height()), fx, fy, $urandom);
    endtask

    task automatic source_pause();
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            cmd_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    // Drop valid and hold until every expected result has been taken
    task automatic wait_idle();
        cmd_bus.valid <= 1'b0;
        while (read_color_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_ENABLED: reg_enable = data[0];
            CFG_WIDTH:   reg_width  = data;
            CFG_HEIGHT:  reg_height = data;
            default:     ;
        endcase
        @(posedge clk);
    endtask

    task automatic program_regs(input logic [CFG_DATA_W-1:0] en, input logic [CFG_DATA_W-1:0] w,
                                input logic [CFG_DATA_W-1:0] h);
        wait_idle();
        reg_write(CFG_ENABLED, en);
        reg_write(CFG_WIDTH, w);
        reg_write(CFG_HEIGHT, h);
    endtask

    task automatic test_disabled_engine();
        program_regs(8'h00, RESET_DIM, RESET_DIM);
        send_cmd(KIND_GET, 12'd0, 12'd0, 12'd0, 12'd0, 32'h0);
        send_cmd(KIND_PUT, 12'd3, 12'd3, 12'd0, 12'd0, 32'hDEAD_BEEF);
        send_cmd(KIND_CLEAR, 12'd0, 12'd0, 12'd0, 12'd0, 32'h1234_5678);
        send_cmd(KIND_FILL, 12'd0, 12'd0, 12'd4, 12'd4, 32'hFFFF_FFFF);
        send_cmd(KIND_LINE, 12'd0, 12'd0, 12'd9, 12'd9, 32'hA5A5_A5A5);
        send_cmd(KIND_RSVD_7, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 32'hFFFF_FFFF);
    endtask

    task automatic test_basic_ops();
        // Full-area clear first so every store word is set before any read
        program_regs(8'h01, RESET_DIM, RESET_DIM);
        send_cmd(KIND_CLEAR, 12'd0, 12'd0, 12'd0, 12'd0, $urandom);
        send_cmd(KIND_PUT, 12'd0, 12'd0, 12'd0, 12'd0, 32'h0000_0000);
        send_cmd(KIND_PUT, 12'd127, 12'd127, 12'hFFF, 12'hFFF, 32'hFFFF_FFFF);
        send_cmd(KIND_GET, 12'd0, 12'd0, 12'd0, 12'd0, 32'h0);
        send_cmd(KIND_GET, 12'd127, 12'd127, 12'd0, 12'd0, 32'h0);
        send_cmd(KIND_PUT, 12'd128, 12'd5, 12'd0, 12'd0, 32'h5555_5555);
        send_cmd(KIND_PUT, 12'hFFF, 12'hFFF, 12'd0, 12'd0, 32'hAAAA_AAAA);
        send_cmd(KIND_GET, 12'hFFF, 12'hFFF, 12'd0, 12'd0, 32'h0);
        send_cmd(KIND_FILL, 12'd10, 12'd10, 12'd0, 12'd5, 32'h0F0F_0F0F);
        send_cmd(KIND_FILL, 12'd10, 12'd10, 12'd5, 12'd0, 32'hF0F0_F0F0);
        send_cmd(KIND_GET, 12'd10, 12'd10, 12'd0, 12'd0, 32'h0);
        send_cmd(KIND_FILL, 12'd120, 12'd120, 12'hFFF, 12'hFFF, 32'h3C3C_3C3C);
        send_cmd(KIND_GET, 12'd127, 12'd127, 12'd0, 12'd0, 32'h0);
        send_cmd(KIND_LINE, 12'd50, 12'd60, 12'd50, 12'd60, 32'h0BAD_F00D);
        send_cmd(KIND_GET, 12'd50, 12'd60, 12'd0, 12'd0, 32'h0);
        send_cmd(KIND_LINE, 12'd10, 12'd40, 12'd3, 12'd2, 32'hC0DE_CAFE);
        send_cmd(KIND_LINE, 12'd0, 12'd0, 12'hFFF, 12'hFFF, 32'h7777_7777);
        send_cmd(KIND_GET, 12'd5, 12'd5, 12'd0, 12'd0, 32'h0);
        send_cmd(KIND_RSVD_5, 12'd1, 12'd1, 12'd1, 12'd1, 32'h1111_1111);
        send_cmd(KIND_RSVD_6, 12'd2, 12'd2, 12'd2, 12'd2, 32'h2222_2222);
    endtask

    task automatic test_register_sweep();
        logic [CFG_DATA_W-1:0] en_set [PHASE_COUNT];
        logic [CFG_DATA_W-1:0] w_set  [PHASE_COUNT];
        logic [CFG_DATA_W-1:0] h_set  [PHASE_COUNT];
        en_set = '{8'h01, 8'hFF, 8'h01, 8'h03, 8'h01, 8'hFE, 8'h01, 8'h81, 8'h01, 8'h01};
        w_set  = '{8'd128, 8'd1, 8'd255, 8'd0, 8'd23, 8'd40, 8'd16, 8'd128, 8'd1, 8'd45};
        h_set  = '{8'd128, 8'd1, 8'd200, 8'd17, 8'd0, 8'd40, 8'd9, 8'd1, 8'd128, 8'd70};
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            program_regs(en_set[p], w_set[p], h_set[p]);
            if (p == 3)
                reg_write(CFG_SPARE, 8'hA5);
            // Every third phase runs with no idling on either side
            quiet = (p % 3 == 2);
            repeat (PHASE_ITEMS)
            begin
                send_random();
                source_pause();
            end
        end
        quiet = 1'b0;
    endtask

    task automatic test_backpressure();
        wait_idle();
        @(posedge clk);
        hold_request = HOLD_CYCLES;
        // Keep offering back to back so the engine fills and stalls its input
        repeat (12) send_random();
        wait_idle();
    endtask

    task automatic test_final_stream();
        quiet = 1'b1;
        repeat (40) send_random();
        wait_idle();
    endtask

    initial
    begin : sink_ready
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left = 0;
        res_bus.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_bus.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                res_bus.ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 4);
                res_bus.ready <= 1'b0;
            end
            else
                res_bus.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : result_check
        logic [COLOR_W-1:0] expected;
        if (rst_n && res_bus.valid === 1'b1 && res_bus.ready === 1'b1)
        begin
            if (read_color_q.size() == 0)
            begin
                $error("read_color: no result expected, actual %h", res_bus.read_color);
                mismatches++;
            end
            else
            begin
                expected = read_color_q.pop_front();
                results_checked++;
                if (res_bus.read_color !== expected)
                begin
                    $error("read_color: expected %h, actual %h", expected, res_bus.read_color);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((cmd_bus.valid === 1'b1 && cmd_bus.ready === 1'b1) ||
            (res_bus.valid === 1'b1 && res_bus.ready === 1'b1) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Timeout after %0d cycles with no transfer", idle_cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        cmd_bus.valid = 1'b0;
        cmd_bus.kind  = '0;
        cmd_bus.pos_x = '0;
        cmd_bus.pos_y = '0;
        cmd_bus.far_x = '0;
        cmd_bus.far_y = '0;
        cmd_bus.color = '0;
        reg_enable    = 1'b0;
        reg_width     = RESET_DIM;
        reg_height    = RESET_DIM;
        idle_cycles   = 0;
        hold_request  = 0;
        quiet         = 1'b0;
        commands_sent = 0;
        results_checked = 0;
        mismatches    = 0;
        foreach (kind_seen[i])
            kind_seen[i] = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_disabled_engine();
        test_basic_ops();
        test_register_sweep();
        test_backpressure();
        test_final_stream();

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("%0d results, %0d commands: clr %0d put %0d get %0d fill %0d line %0d other %0d",
                 results_checked, commands_sent, kind_seen[KIND_CLEAR], kind_seen[KIND_PUT],
                 kind_seen[KIND_GET], kind_seen[KIND_FILL], kind_seen[KIND_LINE],
                 kind_seen[KIND_RSVD_5] + kind_seen[KIND_RSVD_6] + kind_seen[KIND_RSVD_7]);
        $display("Areas: disabled, zero, single pixel, strips, full, oversized; %0d mismatches",
                 mismatches);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
